// ----- design/oaa_pkg.sv -----
// ----------------------------------------------------------------------------
// oaa_pkg: shared types and constants for the overlap-add accumulator
// Opcodes, command kinds, back-end states and register widths.
// ----------------------------------------------------------------------------
package oaa_pkg;

    localparam int OPCODE_W = 2;
    localparam int OFFSET_W = 11;
    localparam int CFG_W    = 11;
    localparam int KIND_W   = 3;

    localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;
    localparam int               LEN_MAX   = 2047;

    localparam logic [OPCODE_W-1:0] OP_TAKE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAKE,
        KIND_ADD,
        KIND_PEEK,
        KIND_DROP,
        KIND_NONE
    } t_kind;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

// ----- design/oaa_front.sv -----
// ----------------------------------------------------------------------------
// oaa_front: request decode and ring addressing
// Holds the length register and read pointer, classifies each request and
// resolves its ring address before handing it to the command queue.
// ----------------------------------------------------------------------------
module oaa_front import oaa_pkg::*; #(
    parameter int DEPTH        = 1024,
    parameter int SAMPLE_WIDTH = 24,
    parameter int ADDR_W       = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [OPCODE_W-1:0]     i_opcode,
    input  logic [OFFSET_W-1:0]     i_offset,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_q_ready,
    input  logic                    i_clearing,
    output logic                    o_push,
    output t_kind                   o_kind,
    output logic [ADDR_W-1:0]       o_addr,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);

    localparam int               CAP_INT = (DEPTH > LEN_MAX) ? LEN_MAX : DEPTH;
    localparam logic [CFG_W-1:0] LEN_CAP = CFG_W'(CAP_INT);

    function automatic logic [CFG_W-1:0] eff_of(input logic [CFG_W-1:0] len);
        logic [CFG_W-1:0] r;
        if (len == '0) begin
            r = CFG_W'(1);
        end else if (len > LEN_CAP) begin
            r = LEN_CAP;
        end else begin
            r = len;
        end
        return r;
    endfunction

    logic [CFG_W-1:0] r_eff, n_eff;
    logic [CFG_W-1:0] r_ptr, n_ptr;

    logic             w_accept;
    logic [CFG_W:0]   w_pos;
    logic [CFG_W:0]   w_wrap;
    logic [CFG_W-1:0] w_next;
    logic             w_off_ok;
    logic [31:0]      w_pos32;
    logic [31:0]      w_ptr32;

    assign o_ready  = i_q_ready && !i_clearing;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;
    assign o_sample = i_sample;

    assign w_pos    = {1'b0, r_ptr} + {1'b0, i_offset};
    assign w_wrap   = (w_pos >= {1'b0, r_eff}) ? (w_pos - {1'b0, r_eff}) : w_pos;
    assign w_off_ok = i_offset < r_eff;
    assign w_next   = r_ptr + CFG_W'(1);
    assign w_pos32  = 32'(w_wrap);
    assign w_ptr32  = 32'(r_ptr);

    always_comb begin
        n_eff  = r_eff;
        n_ptr  = r_ptr;
        o_kind = KIND_NONE;
        o_addr = w_pos32[ADDR_W-1:0];
        if (i_cfg_we) begin
            n_eff = eff_of(i_cfg_wdata);
            if (r_ptr >= n_eff) begin
                n_ptr = '0;
            end
        end
        case (i_opcode)
            OP_TAKE: begin
                o_kind = KIND_TAKE;
                o_addr = w_ptr32[ADDR_W-1:0];
                if (w_accept) begin
                    n_ptr = (w_next >= r_eff) ? '0 : w_next;
                end
            end
            OP_ADD: begin
                o_kind = w_off_ok ? KIND_ADD : KIND_DROP;
            end
            OP_PEEK: begin
                o_kind = w_off_ok ? KIND_PEEK : KIND_NONE;
            end
            default: begin
                o_kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff <= eff_of(LEN_RESET);
            r_ptr <= '0;
        end else begin
            r_eff <= n_eff;
            r_ptr <= n_ptr;
        end
    end

endmodule

// ----- design/oaa_queue.sv -----
// ----------------------------------------------------------------------------
// oaa_queue: two-entry command queue
// Decouples request decode from the store sequencer.
// ----------------------------------------------------------------------------
module oaa_queue #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, n_wr;
    logic             r_rd, n_rd;
    logic [1:0]       r_count, n_count;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = !r_wr;
        end
        if (i_pop) begin
            n_rd = !r_rd;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- design/oaa_back.sv -----
// ----------------------------------------------------------------------------
// oaa_back: sample store sequencer
// Owns the sample memory, clears it after reset, and runs each command as
// a read, a write-back for take and add, and a result into the output register.
// ----------------------------------------------------------------------------
module oaa_back import oaa_pkg::*; #(
    parameter int DEPTH        = 1024,
    parameter int SAMPLE_WIDTH = 24,
    parameter int ADDR_W       = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_pop,
    input  t_kind                   i_cmd_kind,
    input  logic [ADDR_W-1:0]       i_cmd_addr,
    input  logic [SAMPLE_WIDTH-1:0] i_cmd_sample,
    output logic                    o_clearing,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample,
    output logic                    o_discarded
);

    localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [ADDR_W-1:0]       LAST = ADDR_W'(DEPTH - 1);

    logic [SAMPLE_WIDTH-1:0] r_store [DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_rd_data;

    t_back_state             r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    t_kind                   r_kind, n_kind;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic [SAMPLE_WIDTH-1:0] r_smp, n_smp;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample, n_out_sample;
    logic                    r_out_disc, n_out_disc;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [SAMPLE_WIDTH-1:0] w_wdata;
    logic                    w_out_free;
    logic signed [SAMPLE_WIDTH:0] w_sum;
    logic [SAMPLE_WIDTH-1:0] w_sat;

    assign o_clearing  = r_state == BK_CLEAR;
    assign o_valid     = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_discarded = r_out_disc;
    assign w_out_free  = !r_out_valid || i_ready;

    assign w_sum = {r_rd_data[SAMPLE_WIDTH-1], r_rd_data}
                 + {r_smp[SAMPLE_WIDTH-1], r_smp};
    always_comb begin
        if (w_sum[SAMPLE_WIDTH] != w_sum[SAMPLE_WIDTH-1]) begin
            w_sat = w_sum[SAMPLE_WIDTH] ? SMIN : SMAX;
        end else begin
            w_sat = w_sum[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_smp        = r_smp;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sample = r_out_sample;
        n_out_disc   = r_out_disc;
        o_cmd_pop    = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        case (r_state)
            BK_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = i_cmd_kind;
                    n_addr    = i_cmd_addr;
                    n_smp     = i_cmd_sample;
                    n_state   = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = '0;
                    n_out_disc   = 1'b0;
                    n_state      = BK_IDLE;
                    case (r_kind)
                        KIND_TAKE: begin
                            n_out_sample = r_rd_data;
                            w_we         = 1'b1;
                        end
                        KIND_ADD: begin
                            w_we    = 1'b1;
                            w_wdata = w_sat;
                        end
                        KIND_PEEK: begin
                            n_out_sample = r_rd_data;
                        end
                        KIND_DROP: begin
                            n_out_disc = 1'b1;
                        end
                        default: begin
                            n_out_sample = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (o_cmd_pop) begin
            r_rd_data <= r_store[i_cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_addr       <= n_addr;
        r_smp        <= n_smp;
        r_out_sample <= n_out_sample;
        r_out_disc   <= n_out_disc;
    end

endmodule

// ----- design/overlap_add_accumulator.sv -----
// Path: an accepted request goes through the command queue, the back-end store
// read and the output register to m_axis_tvalid. The sequencer runs commands one
// at a time, a read and then its execution, and stalls while its output register is full.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the store
// with s_axis_tready low. Config writes are taken throughout.
// ----------------------------------------------------------------------------
// overlap_add_accumulator: overlap-add synthesis ring
// Take-and-clear, saturating add and peek on a ring of Q1.23 samples.
// ----------------------------------------------------------------------------
module overlap_add_accumulator import oaa_pkg::*; #(
    parameter int DEPTH        = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_W-1:0]                       i_cfg_wdata,  // buffer_length
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // offset, sample
    input  logic [((OFFSET_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic [OPCODE_W-1:0]                    s_axis_tuser, // opcode
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata, // out_sample
    output logic                                   m_axis_tuser  // discarded
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OUT_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int QW     = KIND_W + ADDR_W + SAMPLE_WIDTH;

    logic                    w_push;
    t_kind                   w_f_kind;
    logic [ADDR_W-1:0]       w_f_addr;
    logic [SAMPLE_WIDTH-1:0] w_f_sample;
    logic                    w_q_ready;
    logic                    w_q_valid;
    logic [QW-1:0]           w_q_out;
    logic                    w_pop;
    logic                    w_clearing;
    logic [SAMPLE_WIDTH-1:0] w_out_sample;

    oaa_front #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_offset    (s_axis_tdata[OFFSET_W-1:0]),
        .i_sample    (s_axis_tdata[OFFSET_W +: SAMPLE_WIDTH]),
        .i_q_ready   (w_q_ready),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_kind      (w_f_kind),
        .o_addr      (w_f_addr),
        .o_sample    (w_f_sample)
    );

    oaa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_kind, w_f_addr, w_f_sample}),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    oaa_back #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .o_cmd_pop    (w_pop),
        .i_cmd_kind   (t_kind'(w_q_out[QW-1 -: KIND_W])),
        .i_cmd_addr   (w_q_out[SAMPLE_WIDTH +: ADDR_W]),
        .i_cmd_sample (w_q_out[SAMPLE_WIDTH-1:0]),
        .o_clearing   (w_clearing),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_sample     (w_out_sample),
        .o_discarded  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(w_out_sample);

endmodule
